### rtl/sust_pkg.sv
// shared types for the sorted set table: command and status codes,
// and the command and status bundles between controller and datapath
// no dependencies
package sust_pkg;

  localparam int unsigned ValW = 32;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_LIST   = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_ABSENT    = 3'd3,
    ST_FULL      = 3'd4,
    ST_ENTRY     = 3'd5,
    ST_EMPTY     = 3'd6
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic    capture;  // latch the requested value
    logic    compare;  // register the per-cell compare results
    logic    insert;   // open a gap and write the value
    logic    remove;   // close the gap over the matching cell
    logic    rotate;   // move the chain one place towards cell 0 while listing
    logic    load;     // load the output register
    status_t status;
    logic    last;
  } cmd_bus_t;

  // datapath to controller
  typedef struct packed {
    logic match;      // an occupied cell equals the value
    logic occ_zero;
    logic occ_full;
    logic list_last;  // the entry now at cell 0 is the final one of the list
  } sts_bus_t;

endpackage

### rtl/sorted_unique_set_table.sv
// top level of the sorted set table: controller and cell-chain datapath
// depends on sust_pkg, sust_ctrl, sust_dpath
//
// keeps up to CAPACITY distinct signed 32-bit values in ascending order in a
// chain of register cells, each with its own less-than and equality
// comparator against the requested value. an insert or remove transfer is
// accepted, then registers the compare vector of all cells, then shifts the
// chain open (insert) or closed (remove) and loads its single result, which
// waits while the result register is still full; the next input is accepted
// in the cycle after that load, so a new insert or remove is not taken
// before the last one is through.
// a list transfer rotates the chain one place per emitted entry (or emits
// one result, status empty, on an empty table), takes no new input until its
// last result is loaded and leaves the chain in its original order. results
// sit in an output register, so an item can be accepted while the previous
// result still waits to be taken. command code three is accepted and dropped
// without a result. no clearing pass is needed after reset: cells beyond the
// occupancy are never compared or emitted.
module sorted_unique_set_table #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_command,
  input  logic signed [31:0]               in_value,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [2:0]                       out_status,
  output logic signed [31:0]               out_entry,
  output logic                             out_last
);

  // command and status bundles between the two halves
  sust_pkg::cmd_bus_t cmd;
  sust_pkg::sts_bus_t sts;

  // sequencing, handshakes and result valid
  sust_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // cell chain, counters and result payload
  sust_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_value   (in_value),
    .cmd        (cmd),
    .sts        (sts),
    .out_status (out_status),
    .out_entry  (out_entry),
    .out_last   (out_last)
  );

endmodule

### rtl/sust_dpath.sv
// datapath of the sorted set table: cell chain with per-cell comparators,
// occupancy and list counters, output payload register
// depends on sust_pkg
module sust_dpath #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic signed [sust_pkg::ValW-1:0]      in_value,
  input  sust_pkg::cmd_bus_t                    cmd,
  output sust_pkg::sts_bus_t                    sts,
  output logic [2:0]                            out_status,
  output logic signed [sust_pkg::ValW-1:0]      out_entry,
  output logic                                  out_last
);

  localparam int unsigned OW = $clog2(CAPACITY + 1);

  logic signed [sust_pkg::ValW-1:0] val_r;
  logic signed [sust_pkg::ValW-1:0] cell_r   [CAPACITY];
  logic signed [sust_pkg::ValW-1:0] cell_nxt [CAPACITY];
  logic signed [sust_pkg::ValW-1:0] prev_val [CAPACITY];
  logic signed [sust_pkg::ValW-1:0] next_val [CAPACITY];
  logic [CAPACITY-1:0]              lt_c;
  logic [CAPACITY-1:0]              eq_c;
  logic [CAPACITY-1:0]              lt_r;
  logic [CAPACITY-1:0]              lt_prev;
  logic                             match_r;
  logic [OW-1:0]                    occ_r;
  logic [OW-1:0]                    lst_idx_r;
  logic [2:0]                       status_r;
  logic signed [sust_pkg::ValW-1:0] entry_r;
  logic                             last_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      val_r <= in_value;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    // only occupied cells take part in the compare
    assign lt_c[i] = (OW'(i) < occ_r) && (cell_r[i] < val_r);
    assign eq_c[i] = (OW'(i) < occ_r) && (cell_r[i] == val_r);

    if (i == 0) begin : g_head
      assign lt_prev[i]  = 1'b1;
      assign prev_val[i] = val_r;
    end else begin : g_body
      assign lt_prev[i]  = lt_r[i-1];
      assign prev_val[i] = cell_r[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_val[i] = cell_r[0];
    end else begin : g_mid
      assign next_val[i] = cell_r[i+1];
    end

    always_comb begin
      cell_nxt[i] = cell_r[i];
      if (cmd.insert) begin
        if (!lt_r[i]) begin
          cell_nxt[i] = lt_prev[i] ? val_r : prev_val[i];
        end
      end else if (cmd.remove) begin
        if (!lt_r[i]) begin
          cell_nxt[i] = next_val[i];
        end
      end else if (cmd.rotate) begin
        // the last occupied cell wraps round to the head value
        cell_nxt[i] = (OW'(i + 1) == occ_r) ? cell_r[0] : next_val[i];
      end
    end

    always_ff @(posedge clk) begin
      cell_r[i] <= cell_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      lt_r    <= lt_c;
      match_r <= |eq_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r     <= '0;
      lst_idx_r <= '0;
    end else begin
      if (cmd.insert) begin
        occ_r <= occ_r + OW'(1);
      end else if (cmd.remove) begin
        occ_r <= occ_r - OW'(1);
      end
      if (cmd.rotate) begin
        lst_idx_r <= sts.list_last ? '0 : lst_idx_r + OW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status_r <= cmd.status;
      last_r   <= cmd.last;
      unique case (cmd.status)
        sust_pkg::ST_ENTRY: entry_r <= cell_r[0];
        sust_pkg::ST_EMPTY: entry_r <= '0;
        default:            entry_r <= val_r;
      endcase
    end
  end

  assign sts.match     = match_r;
  assign sts.occ_zero  = (occ_r == '0);
  assign sts.occ_full  = (occ_r == OW'(CAPACITY));
  assign sts.list_last = ((lst_idx_r + OW'(1)) == occ_r);

  assign out_status = status_r;
  assign out_entry  = entry_r;
  assign out_last   = last_r;

endmodule

### rtl/sust_ctrl.sv
// controller of the sorted set table: command sequencing and output valid
// depends on sust_pkg
module sust_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_command,
  output logic               out_valid,
  input  logic               out_ready,
  input  sust_pkg::sts_bus_t sts,
  output sust_pkg::cmd_bus_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_APPLY,
    S_LIST
  } state_t;

  state_t     state_r;
  logic [1:0] cmd_r;
  logic       out_valid_r;
  logic       accept;
  logic       slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd         = '0;
    cmd.status  = sust_pkg::ST_INSERTED;
    cmd.capture = accept;
    unique case (state_r)
      S_IDLE: begin
      end
      S_CMP: begin
        cmd.compare = 1'b1;
      end
      S_APPLY: begin
        if (slot_free) begin
          cmd.load = 1'b1;
          cmd.last = 1'b1;
          if (cmd_r == sust_pkg::CMD_INSERT) begin
            priority if (sts.match) begin
              cmd.status = sust_pkg::ST_DUPLICATE;
            end else if (sts.occ_full) begin
              cmd.status = sust_pkg::ST_FULL;
            end else begin
              cmd.status = sust_pkg::ST_INSERTED;
              cmd.insert = 1'b1;
            end
          end else begin
            if (sts.match) begin
              cmd.status = sust_pkg::ST_REMOVED;
              cmd.remove = 1'b1;
            end else begin
              cmd.status = sust_pkg::ST_ABSENT;
            end
          end
        end
      end
      S_LIST: begin
        if (slot_free) begin
          cmd.load = 1'b1;
          if (sts.occ_zero) begin
            cmd.status = sust_pkg::ST_EMPTY;
            cmd.last   = 1'b1;
          end else begin
            cmd.status = sust_pkg::ST_ENTRY;
            cmd.last   = sts.list_last;
            cmd.rotate = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cmd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            cmd_r <= in_command;
            unique case (in_command)
              sust_pkg::CMD_INSERT,
              sust_pkg::CMD_REMOVE: state_r <= S_CMP;
              sust_pkg::CMD_LIST:   state_r <= S_LIST;
              default:              state_r <= S_IDLE;
            endcase
          end
        end
        S_CMP: begin
          state_r <= S_APPLY;
        end
        S_APPLY: begin
          if (slot_free) begin
            state_r <= S_IDLE;
          end
        end
        S_LIST: begin
          if (slot_free && cmd.last) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/sust_chk.sv
// port-level checks for the sorted set table, bound to the top level
// depends on sust_pkg and sorted_unique_set_table
module sust_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [1:0]         in_command,
  input logic signed [31:0] in_value,
  input logic               out_valid,
  input logic               out_ready,
  input logic [2:0]         out_status,
  input logic signed [31:0] out_entry,
  input logic               out_last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_entry) && $stable(out_last))
    else $error("result changed while stalled");

  // any real command keeps the input side closed in the next cycle
  a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_command == sust_pkg::CMD_INSERT ||
      in_command == sust_pkg::CMD_REMOVE || in_command == sust_pkg::CMD_LIST)
    |=> !in_ready)
    else $error("input accepted while a command is in progress");

  // every result other than a list entry is the only one of its transfer
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != sust_pkg::ST_ENTRY |-> out_last)
    else $error("single result without last");

  // the empty list result carries a zero entry
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == sust_pkg::ST_EMPTY |-> out_entry == 32'sd0)
    else $error("empty list result with non-zero entry");

endmodule

bind sorted_unique_set_table sust_chk u_sust_chk (.*);
